// ===== src/ccsr_pkg.sv =====
`default_nettype none

package ccsr_pkg;

  // Radius saturation bound and register reset values
  localparam int unsigned MaxRadius    = 32;
  localparam logic [5:0]  MAX_RADIUS   = 6'(MaxRadius);
  localparam logic [11:0] RESET_WIDTH  = 12'd480;
  localparam logic [11:0] RESET_HEIGHT = 12'd320;
  localparam logic [11:0] RESET_PITCH  = 12'd480;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_LINE_PITCH    = 2'd2
  } cfg_reg_t;

  // One circle
  typedef struct packed {
    logic signed [11:0] center_x;
    logic signed [11:0] center_y;
    logic        [5:0]  radius;
    logic        [31:0] fill_color;
  } in_item_t;

  // One span
  typedef struct packed {
    logic signed [12:0] span_row;
    logic        [11:0] span_x;
    logic        [6:0]  span_len;
    logic        [23:0] word_offset;
    logic        [31:0] span_color;
    logic               span_last;
  } out_item_t;

  // Configuration register file contents
  typedef struct packed {
    logic [11:0] screen_width;
    logic [11:0] screen_height;
    logic [11:0] line_pitch;
  } cfg_regs_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic settled;
    logic last_row;
    logic pipe_empty;
  } dp_status_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } ctrl_state_t;

endpackage

`default_nettype wire

// ===== src/ccsr_cfg_regs.sv =====
`default_nettype none

module ccsr_cfg_regs (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [11:0]         cfg_wdata,
  output ccsr_pkg::cfg_regs_t      regs
);
  import ccsr_pkg::*;

  cfg_regs_t regs_r, regs_nxt;

  // Always able to take a transfer
  assign cfg_ready = 1'b1;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH:  regs_nxt.screen_width  = cfg_wdata;
        REG_SCREEN_HEIGHT: regs_nxt.screen_height = cfg_wdata;
        REG_LINE_PITCH:    regs_nxt.line_pitch    = cfg_wdata;
        default:           regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.screen_width  <= RESET_WIDTH;
      regs_r.screen_height <= RESET_HEIGHT;
      regs_r.line_pitch    <= RESET_PITCH;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

`default_nettype wire

// ===== src/ccsr_ctrl.sv =====
`default_nettype none

module ccsr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire ccsr_pkg::dp_status_t status,
  output ccsr_pkg::ctrl_cmd_t      cmd
);
  import ccsr_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_RUN;
      ST_RUN:   if (status.settled && status.last_row) state_nxt = ST_DRAIN;
      ST_DRAIN: if (status.pipe_empty) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_RUN:   cmd.step = 1'b1;
      ST_DRAIN: cmd = '0;
      default:  busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/ccsr_datapath.sv =====
`default_nettype none

module ccsr_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ccsr_pkg::ctrl_cmd_t  cmd,
  input  wire ccsr_pkg::in_item_t   in_item,
  input  wire ccsr_pkg::cfg_regs_t  regs,
  output ccsr_pkg::dp_status_t      status,
  output logic                      out_strobe,
  output ccsr_pkg::out_item_t       out_item
);
  import ccsr_pkg::*;

  // Held circle
  logic signed [11:0] cx_r, cy_r;
  logic        [5:0]  rad_r;
  logic        [31:0] color_r;
  logic        [5:0]  last_idx_r;

  // Row walker and half-width tracker: v = r*r - (r-i)^2, sq = h*h
  logic        [5:0]  idx_r, idx_nxt;
  logic        [10:0] v_r, v_nxt;
  logic signed [6:0]  dv_r, dv_nxt;
  logic        [5:0]  h_r, h_nxt;
  logic        [10:0] sq_r, sq_nxt;

  // Clip stage
  logic               a_valid_r;
  logic signed [12:0] a_row_r;
  logic        [11:0] a_x_r;
  logic        [6:0]  a_len_r;
  logic               a_pos_r;
  logic               a_last_r;

  // Output stage
  logic               out_strobe_r;
  out_item_t          out_r;

  logic        [5:0]  rad_sat;
  logic        [11:0] sq_up;
  logic               go_up, go_down, settled, emit;
  logic signed [11:0] v_sum;

  logic signed [13:0] row_s, xofs, len0, x1, len1, len2;
  logic               row_ok, pos;
  logic        [23:0] prod;

  // Saturate radius on load
  assign rad_sat = (in_item.radius > MAX_RADIUS) ? MAX_RADIUS : in_item.radius;

  // Half-width moves one step a cycle until h*h <= v < (h+1)^2
  assign sq_up   = {1'b0, sq_r} + {5'b0, h_r, 1'b0} + 12'd1;
  assign go_up   = sq_up <= {1'b0, v_r};
  assign go_down = sq_r > v_r;
  assign settled = !go_up && !go_down;
  assign emit    = cmd.step && settled;
  assign v_sum   = $signed({1'b0, v_r}) + 12'(dv_r);

  always_comb begin
    idx_nxt = idx_r;
    v_nxt   = v_r;
    dv_nxt  = dv_r;
    h_nxt   = h_r;
    sq_nxt  = sq_r;
    if (cmd.load) begin
      idx_nxt = '0;
      v_nxt   = '0;
      dv_nxt  = 7'($signed({1'b0, rad_sat, 1'b0}) - 8'sd1);
      h_nxt   = '0;
      sq_nxt  = '0;
    end else if (cmd.step) begin
      if (go_up) begin
        h_nxt  = h_r + 6'd1;
        sq_nxt = sq_up[10:0];
      end else if (go_down) begin
        h_nxt  = h_r - 6'd1;
        sq_nxt = sq_r - {4'b0, h_r, 1'b0} + 11'd1;
      end else begin
        idx_nxt = idx_r + 6'd1;
        v_nxt   = v_sum[10:0];
        dv_nxt  = dv_r - 7'sd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r       <= in_item.center_x;
      cy_r       <= in_item.center_y;
      rad_r      <= rad_sat;
      color_r    <= in_item.fill_color;
      last_idx_r <= (rad_sat == 6'd0) ? 6'd0 : 6'({rad_sat, 1'b0} - 7'd1);
    end
    idx_r <= idx_nxt;
    v_r   <= v_nxt;
    dv_r  <= dv_nxt;
    h_r   <= h_nxt;
    sq_r  <= sq_nxt;
  end

  // Vertical and horizontal clipping of the current row
  always_comb begin
    row_s  = {{2{cy_r[11]}}, cy_r} - $signed({8'b0, rad_r}) + $signed({8'b0, idx_r});
    row_ok = !row_s[13] && (row_s < $signed({2'b0, regs.screen_height}));
    xofs   = {{2{cx_r[11]}}, cx_r} - $signed({8'b0, h_r});
    len0   = $signed({7'b0, h_r, 1'b0});
    if (xofs[13]) begin
      x1   = '0;
      len1 = len0 + xofs;
    end else begin
      x1   = xofs;
      len1 = len0;
    end
    if ((x1 + len1) >= $signed({2'b0, regs.screen_width})) begin
      len2 = $signed({2'b0, regs.screen_width}) - x1;
    end else begin
      len2 = len1;
    end
    pos = row_ok && !len2[13] && (len2 != 14'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      a_row_r  <= row_s[12:0];
      a_x_r    <= pos ? x1[11:0] : 12'd0;
      a_len_r  <= pos ? len2[6:0] : 7'd0;
      a_pos_r  <= pos;
      a_last_r <= (idx_r == last_idx_r);
    end
  end

  // Frame buffer word offset
  assign prod = {12'b0, a_row_r[11:0]} * {12'b0, regs.line_pitch};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid_r) begin
      out_r.span_row    <= a_row_r;
      out_r.span_x      <= a_x_r;
      out_r.span_len    <= a_len_r;
      out_r.word_offset <= a_pos_r ? (prod + {12'b0, a_x_r}) : 24'd0;
      out_r.span_color  <= color_r;
      out_r.span_last   <= a_last_r;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_item          = out_r;
  assign status.settled    = settled;
  assign status.last_row   = (idx_r == last_idx_r);
  assign status.pipe_empty = !a_valid_r && !out_strobe_r;

endmodule

`default_nettype wire

// ===== src/clipped_circle_span_rasterizer.sv =====
// Channel   Ports                                   Transfer
// -------   -------------------------------------   -----------------------------
// in        start, busy, in_item                    start high while busy low
// out       out_strobe, out_item                    out_strobe high, one cycle
// cfg       cfg_valid, cfg_ready, cfg_index,        cfg_valid and cfg_ready high
//           cfg_wdata
//
// A circle of radius r gives max(2r,1) spans. For r > 0 busy is high through the
// 2r spans, the steps of the half-width tracker up to r and back down, and the
// drain of the clip and output stages. A zero radius also keeps busy high
// through its one span and the drain; the next circle can transfer in the first
// cycle that busy is low, after the last span has left.
// Synchronous active-low reset; registers come back at 480 / 320 / 480.
// Spans cannot be stalled; out_strobe marks each for exactly one cycle.
`default_nettype none

module clipped_circle_span_rasterizer (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire ccsr_pkg::in_item_t  in_item,
  output logic                     out_strobe,
  output ccsr_pkg::out_item_t      out_item,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [11:0]         cfg_wdata
);
  import ccsr_pkg::*;

  cfg_regs_t  regs;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  ccsr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (regs)
  );

  ccsr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  ccsr_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_item    (in_item),
    .regs       (regs),
    .status     (status),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ccsr_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_strobe;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_reg_t    cfg_index = REG_SCREEN_WIDTH;
  logic [11:0] cfg_wdata = '0;

  // Circles waiting to be sent, spans still owed by the block
  in_item_t  circle_q[$];
  out_item_t expected_spans[$];

  // Own copy of the clip and pitch registers, tracked from cfg transfers
  logic [11:0] vis_width  = RESET_WIDTH;
  logic [11:0] vis_height = RESET_HEIGHT;
  logic [11:0] fb_pitch   = RESET_PITCH;

  int   send_gap_pct = 0;
  bit   hold_circles = 1'b0;
  bit   circle_taken = 1'b0;
  int   circles_taken = 0;
  int   spans_checked = 0;
  int   mismatches = 0;
  int   settings_used = 1;
  int   pause_base;

  clipped_circle_span_rasterizer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Work out every span of one circle and queue them in emission order
  function automatic void trace_circle(in_item_t c);
    int        cx, cy, r, rows, row, d, area, h, len, xofs, ofs;
    int        w, ht, p;
    out_item_t s;
    cx = $signed(c.center_x);
    cy = $signed(c.center_y);
    r  = c.radius;
    w  = vis_width;
    ht = vis_height;
    p  = fb_pitch;
    if (r > MaxRadius) r = MaxRadius;
    rows = 2 * r;
    s.span_color = c.fill_color;
    // zero radius: a single empty span on the centre row
    if (rows == 0) begin
      s.span_row    = 13'(cy);
      s.span_x      = '0;
      s.span_len    = '0;
      s.word_offset = '0;
      s.span_last   = 1'b1;
      expected_spans.push_back(s);
      return;
    end
    for (int i = 0; i < rows; i++) begin
      row  = cy - r + i;
      d    = r - i;
      area = r * r - d * d;
      h    = 0;
      while ((h + 1) * (h + 1) <= area) h++;
      len  = 2 * h;
      xofs = cx - h;
      // vertical clip, then left and right
      if (row < 0 || row >= ht) begin
        len = 0;
      end else begin
        if (xofs < 0) begin
          len  = len + xofs;
          xofs = 0;
        end
        if (xofs + len >= w) len = w - xofs;
        if (len < 0) len = 0;
      end
      if (len > 0) begin
        ofs = row * p + xofs;
      end else begin
        len  = 0;
        xofs = 0;
        ofs  = 0;
      end
      s.span_row    = 13'(row);
      s.span_x      = 12'(xofs);
      s.span_len    = 7'(len);
      s.word_offset = 24'(ofs);
      s.span_last   = (i == rows - 1);
      expected_spans.push_back(s);
    end
  endfunction

  function automatic in_item_t make_circle(int x, int y, int r, logic [31:0] col);
    in_item_t c;
    c.center_x   = 12'(x);
    c.center_y   = 12'(y);
    c.radius     = 6'(r);
    c.fill_color = col;
    return c;
  endfunction

  // Mostly small circles around the visible area, some anywhere, a few oversized
  function automatic in_item_t random_circle();
    int pick, r, m;
    in_item_t c;
    pick = $urandom_range(0, 99);
    if (pick < 70)      r = $urandom_range(0, 12);
    else if (pick < 95) r = $urandom_range(13, 32);
    else                r = $urandom_range(33, 63);
    m = (r > MaxRadius) ? MaxRadius : r;
    if ($urandom_range(0, 3) == 0) begin
      c.center_x = 12'($urandom);
      c.center_y = 12'($urandom);
    end else begin
      c.center_x = 12'(int'($urandom_range(0, int'(vis_width) + 2 * m + 8)) - m - 4);
      c.center_y = 12'(int'($urandom_range(0, int'(vis_height) + 2 * m + 8)) - m - 4);
    end
    c.radius     = 6'(r);
    c.fill_color = $urandom;
    return c;
  endfunction

  // Circle driver: new item only once the current one has transferred
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || circle_taken) begin
      if (!hold_circles && circle_q.size() != 0 &&
          $urandom_range(0, 99) >= send_gap_pct) begin
        in_item <= circle_q.pop_front();
        start   <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: input transfers feed the predictor, spans are checked in order
  always @(posedge clk) begin
    out_item_t want;
    circle_taken = rst_n && start && !busy;
    if (rst_n) begin
      if (circle_taken) begin
        trace_circle(in_item);
        circles_taken++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SCREEN_WIDTH:  vis_width  = cfg_wdata;
          REG_SCREEN_HEIGHT: vis_height = cfg_wdata;
          REG_LINE_PITCH:    fb_pitch   = cfg_wdata;
          default: ;
        endcase
      end
      if (out_strobe) begin
        if (expected_spans.size() == 0) begin
          if (mismatches < 10)
            $display("%t: unexpected span row %0d x %0d len %0d", $realtime,
                     $signed(out_item.span_row), out_item.span_x, out_item.span_len);
          mismatches++;
        end else begin
          want = expected_spans.pop_front();
          spans_checked++;
          if (out_item.span_row !== want.span_row || out_item.span_x !== want.span_x ||
              out_item.span_len !== want.span_len ||
              out_item.word_offset !== want.word_offset ||
              out_item.span_color !== want.span_color ||
              out_item.span_last !== want.span_last) begin
            if (mismatches < 10) begin
              $display("%t: span mismatch", $realtime);
              $display("  exp row %0d x %0d len %0d ofs %0d color %h last %b",
                       $signed(want.span_row), want.span_x, want.span_len,
                       want.word_offset, want.span_color, want.span_last);
              $display("  got row %0d x %0d len %0d ofs %0d color %h last %b",
                       $signed(out_item.span_row), out_item.span_x, out_item.span_len,
                       out_item.word_offset, out_item.span_color, out_item.span_last);
            end
            mismatches++;
          end
        end
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [11:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Block idle: nothing queued, nothing in flight, nothing owed
  task automatic wait_quiet();
    do @(posedge clk);
    while (circle_q.size() != 0 || start || expected_spans.size() != 0 || busy);
  endtask

  task automatic apply_setting(logic [11:0] w, logic [11:0] ht, logic [11:0] p);
    wait_quiet();
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, ht);
    write_reg(REG_LINE_PITCH, p);
    settings_used++;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed circles at the reset settings
    send_gap_pct = 19;
    circle_q.push_back(make_circle(10, 20, 0, 32'h0000_0000));
    circle_q.push_back(make_circle(-2048, -2048, 0, 32'hFFFF_FFFF));
    circle_q.push_back(make_circle(2047, 2047, 0, 32'h1234_5678));
    circle_q.push_back(make_circle(100, 100, 1, 32'hA5A5_A5A5));
    circle_q.push_back(make_circle(240, 160, 32, 32'h5A5A_5A5A));
    circle_q.push_back(make_circle(240, 160, 33, 32'h0F0F_F0F0));
    circle_q.push_back(make_circle(-100, 50, 63, 32'hF0F0_0F0F));
    circle_q.push_back(make_circle(2047, 100, 5, 32'h8000_0001));
    circle_q.push_back(make_circle(-2048, 100, 10, 32'h7FFF_FFFE));
    circle_q.push_back(make_circle(0, 0, 8, 32'hDEAD_BEEF));
    circle_q.push_back(make_circle(479, 319, 8, 32'hCAFE_F00D));
    circle_q.push_back(make_circle(478, 5, 3, 32'h0000_FFFF));
    circle_q.push_back(make_circle(200, 2047, 4, 32'hFFFF_0000));
    circle_q.push_back(make_circle(200, -5, 10, 32'h1111_1111));
    circle_q.push_back(make_circle(-3, 200, 6, 32'h2222_2222));
    circle_q.push_back(make_circle(-1, -1, 2, 32'h3333_3333));
    circle_q.push_back(make_circle(1000, 200, 12, 32'h4444_4444));

    // Small screen; mid-run the sender holds back until all spans are out
    apply_setting(12'd64, 12'd48, 12'd100);
    pause_base = circles_taken;
    repeat (30) circle_q.push_back(random_circle());
    do @(posedge clk); while (circles_taken < pause_base + 12);
    hold_circles = 1'b1;
    do @(posedge clk); while (start || expected_spans.size() != 0);
    hold_circles = 1'b0;

    // Largest registers, slow sender
    apply_setting(12'd4095, 12'd4095, 12'd4095);
    send_gap_pct = 60;
    repeat (25) circle_q.push_back(random_circle());

    // One-pixel screen with zero pitch, then a zero-sized screen
    apply_setting(12'd1, 12'd1, 12'd0);
    repeat (8) circle_q.push_back(random_circle());
    apply_setting(12'd0, 12'd0, 12'd1);
    repeat (7) circle_q.push_back(random_circle());

    // Ordinary screen, sender never idles
    apply_setting(12'd640, 12'd480, 12'd1024);
    send_gap_pct = 0;
    repeat (30) circle_q.push_back(random_circle());

    wait_quiet();
    repeat (140) @(posedge clk);

    $display("Rasterised %0d circles into %0d checked spans", circles_taken, spans_checked);
    $display("across %0d clip/pitch settings, %0d mismatches", settings_used, mismatches);
    if (mismatches == 0 && expected_spans.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout with %0d spans outstanding", expected_spans.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
